// ===== rtl/core/srad_pkg.sv =====
`timescale 1ns / 1ps

package srad_pkg;

  // Memory sizes of the system around the decoder.
  localparam logic [31:0] RAM_BYTES  = 32'd33554432;
  localparam logic [31:0] BIOS_BYTES = 32'd131072;

  // Derived address limits.
  localparam logic [31:0] RAM_LAST  = RAM_BYTES - 32'd1;
  localparam logic [31:0] BIOS_MASK = BIOS_BYTES - 32'd1;

  localparam int LOCAL_W = 25;

  // Result target codes.
  typedef enum logic [1:0] {
    TGT_NONE = 2'd0,
    TGT_DRAM = 2'd1,
    TGT_ROM  = 2'd2
  } target_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_SHADOW = 2'd0,
    REG_SMRAM  = 2'd1,
    REG_BIOS   = 2'd2,
    REG_ISA    = 2'd3
  } reg_index_t;

  // Register reset values.
  localparam logic [15:0] SHADOW_RESET = 16'h0000;
  localparam logic [7:0]  SMRAM_RESET  = 8'h00;
  localparam logic [7:0]  BIOS_RESET   = 8'h78;
  localparam logic [7:0]  ISA_RESET    = 8'hFF;

  // SMRAM control decode masks and matches.
  localparam logic [7:0] SMRAM_E_MASK   = 8'h16;
  localparam logic [7:0] SMRAM_ERR_MASK = 8'h12;
  localparam logic [7:0] SMRAM_ERR_VAL  = 8'h02;

  // One access on the request side.
  typedef struct packed {
    logic        req_type;
    logic [31:0] address;
  } req_t;

  // One decoded access on the response side.
  typedef struct packed {
    target_t              target;
    logic [LOCAL_W-1:0]   local_address;
    logic                 write_dropped;
    logic                 config_error;
  } rsp_t;

  // Chipset control registers as seen by the decoder.
  typedef struct packed {
    logic [15:0] shadow_control;
    logic [7:0]  smram_control;
    logic [7:0]  bios_control;
    logic [7:0]  isa_decode_control;
  } cfg_t;

endpackage

// ===== rtl/core/srad_decode.sv =====
`timescale 1ns / 1ps

module srad_decode (
  input  srad_pkg::cfg_t cfg,
  input  srad_pkg::req_t req,
  output srad_pkg::rsp_t rsp
);

  always_comb begin
    logic [31:0]       a;
    srad_pkg::target_t tgt;
    logic [31:0]       loc;
    logic              prot;
    logic              e_bios;
    logic              f_bios;
    logic              smram_e;
    logic              err;
    logic [15:0]       sh;
    logic              lo_en;
    logic              hi_en;
    logic              half_en;
    logic [1:0]        blk;

    a       = req.address;
    sh      = cfg.shadow_control;
    tgt     = srad_pkg::TGT_NONE;
    loc     = 32'd0;
    prot    = 1'b0;
    e_bios  = cfg.bios_control[6];
    f_bios  = cfg.bios_control[5];
    smram_e = (cfg.smram_control & srad_pkg::SMRAM_E_MASK) == srad_pkg::SMRAM_E_MASK;
    err     = (cfg.smram_control & srad_pkg::SMRAM_ERR_MASK) == srad_pkg::SMRAM_ERR_VAL;
    blk     = a[16:15];

    // Shadow enables of the two 32K halves of the E or F segment.
    if (a[16]) begin
      lo_en = sh[6];
      hi_en = sh[7];
    end else begin
      lo_en = sh[4];
      hi_en = sh[5];
    end
    half_en = a[15] ? hi_en : lo_en;

    if (a[31:16] == 16'hFFFE) begin
      // High alias of the E segment BIOS.
      if (e_bios) begin
        tgt  = srad_pkg::TGT_ROM;
        loc  = a & srad_pkg::BIOS_MASK;
        prot = 1'b1;
      end
    end else if (a[31:16] == 16'hFFFF) begin
      // High alias of the F segment BIOS.
      if (f_bios) begin
        tgt  = srad_pkg::TGT_ROM;
        loc  = a & srad_pkg::BIOS_MASK;
        prot = 1'b1;
      end
    end else if (a[31:16] == 16'h000E && smram_e) begin
      // SMRAM window backed by DRAM at A0000 or B0000.
      tgt = srad_pkg::TGT_DRAM;
      loc = {12'h000, 3'b101, cfg.smram_control[3], a[15:0]};
    end else if (a[31:17] == 15'h0007) begin
      // E or F segment: BIOS window or shadow halves.
      if (a[16] ? f_bios : e_bios) begin
        if (!lo_en && !hi_en) begin
          tgt  = srad_pkg::TGT_ROM;
          loc  = a & srad_pkg::BIOS_MASK;
          prot = 1'b1;
        end else if (half_en) begin
          tgt  = srad_pkg::TGT_DRAM;
          loc  = a;
          prot = sh[8];
        end
      end
    end else if (a[31:17] == 15'h0006) begin
      // C and D segment 32K shadow blocks.
      if (sh[blk]) begin
        tgt = srad_pkg::TGT_DRAM;
        loc = a;
      end
    end else if (a <= 32'h0009FFFF) begin
      // Base 640K.
      if (cfg.isa_decode_control[0]) begin
        tgt = srad_pkg::TGT_DRAM;
        loc = a;
      end
    end else if (a >= 32'h00100000 && a <= srad_pkg::RAM_LAST) begin
      // Extended RAM.
      tgt = srad_pkg::TGT_DRAM;
      loc = a;
    end

    rsp.target        = tgt;
    rsp.local_address = loc[srad_pkg::LOCAL_W-1:0];
    rsp.write_dropped = req.req_type && prot && (tgt != srad_pkg::TGT_NONE);
    rsp.config_error  = err;
  end

endmodule

// ===== rtl/core/shadow_ram_address_decoder.sv =====
`timescale 1ns / 1ps

// Decodes each CPU memory access into DRAM, BIOS ROM or unmapped, with the
// local byte address, from four chipset control registers written through
// the cfg_we / cfg_index / cfg_data port. The block is a two-register pipeline:
// an accepted item is held in an input register, decoded by shallow compare
// logic, and lands in the result register, which raises rsp_valid. One item
// is accepted every cycle while the response side keeps up. Registers must
// only be written while no item is in flight.
module shadow_ram_address_decoder (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  srad_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output srad_pkg::rsp_t rsp,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [15:0]    cfg_data
);

  srad_pkg::cfg_t cfg;
  srad_pkg::req_t s1;
  logic           s1_valid;
  srad_pkg::rsp_t dec;
  logic           s2_load;
  logic           req_take;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.shadow_control     <= srad_pkg::SHADOW_RESET;
      cfg.smram_control      <= srad_pkg::SMRAM_RESET;
      cfg.bios_control       <= srad_pkg::BIOS_RESET;
      cfg.isa_decode_control <= srad_pkg::ISA_RESET;
    end else if (cfg_we) begin
      unique case (srad_pkg::reg_index_t'(cfg_index))
        srad_pkg::REG_SHADOW: cfg.shadow_control     <= cfg_data;
        srad_pkg::REG_SMRAM:  cfg.smram_control      <= cfg_data[7:0];
        srad_pkg::REG_BIOS:   cfg.bios_control       <= cfg_data[7:0];
        srad_pkg::REG_ISA:    cfg.isa_decode_control <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control.
  assign s2_load   = !rsp_valid || !rsp_stall;
  assign req_stall = s1_valid && !s2_load;
  assign req_take  = req_valid && !req_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= req_take || (s1_valid && !s2_load);
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      s1 <= req;
    end
  end

  srad_decode u_decode (
    .cfg (cfg),
    .req (s1),
    .rsp (dec)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s2_load) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load && s1_valid) begin
      rsp <= dec;
    end
  end

  // An unmapped result carries a zero address.
  a_unmapped_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.target == srad_pkg::TGT_NONE) |-> rsp.local_address == '0)
    else $error("unmapped result with nonzero address");

  // A dropped write always has a real target.
  a_drop_target: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.write_dropped |-> rsp.target != srad_pkg::TGT_NONE)
    else $error("dropped write without target");

  // A dropped DRAM write only occurs with the shadow write protection bit set.
  a_drop_rom_or_prot: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.write_dropped && (rsp.target == srad_pkg::TGT_DRAM)
      |-> cfg.shadow_control[8])
    else $error("dropped DRAM write without protection bit");

  // A held input item is not lost while the result side is stalled.
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s2_load |=> s1_valid)
    else $error("input item lost under stall");

  // A loaded result register always follows a valid input item.
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    s2_load && s1_valid |=> rsp_valid)
    else $error("decoded item not presented");

endmodule

// ===== tb/sv/shadow_ram_address_decoder_test.sv =====
`timescale 1ns / 1ps

module shadow_ram_address_decoder_test;

  // One access in flight together with the decode it should produce.
  typedef struct packed {
    srad_pkg::req_t access;
    srad_pkg::rsp_t result;
  } pending_decode_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           req_valid = 1'b0;
  logic           req_stall;
  srad_pkg::req_t req = '0;
  logic           rsp_valid;
  logic           rsp_stall = 1'b0;
  srad_pkg::rsp_t rsp;
  logic           cfg_we = 1'b0;
  logic [1:0]     cfg_index = srad_pkg::REG_SHADOW;
  logic [15:0]    cfg_data = '0;

  // Local copy of the chipset control registers used for decode prediction.
  logic [15:0] shadow_reg = srad_pkg::SHADOW_RESET;
  logic [7:0]  smram_reg  = srad_pkg::SMRAM_RESET;
  logic [7:0]  bios_reg   = srad_pkg::BIOS_RESET;
  logic [7:0]  isa_reg    = srad_pkg::ISA_RESET;

  pending_decode_t pending_decodes[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_go = 1'b0;
  logic hold_begun = 1'b0;
  int hold_left = 0;
  int failures = 0;
  int results_seen = 0;
  int dram_hits = 0;
  int rom_hits = 0;
  int unmapped_hits = 0;
  int dropped_writes = 0;
  int error_flags = 0;
  int settings_used = 0;

  shadow_ram_address_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Decode of an E or F segment address; low_bit is the shadow enable of the
  // lower 32K half, the upper half uses the next bit.
  function automatic void bios_segment_lookup(input logic [31:0] a, input logic enabled,
                                              input int low_bit,
                                              inout srad_pkg::target_t tgt,
                                              inout logic [31:0] loc, inout logic prot);
    logic any_on;
    logic half_on;
    any_on  = shadow_reg[low_bit] | shadow_reg[low_bit + 1];
    half_on = a[15] ? shadow_reg[low_bit + 1] : shadow_reg[low_bit];
    if (enabled) begin
      if (!any_on) begin
        tgt  = srad_pkg::TGT_ROM;
        loc  = a & srad_pkg::BIOS_MASK;
        prot = 1'b1;
      end else if (half_on) begin
        tgt  = srad_pkg::TGT_DRAM;
        loc  = a;
        prot = shadow_reg[8];
      end
    end
  endfunction

  // Expected decode of one access under the current register settings.
  function automatic srad_pkg::rsp_t predict_decode(input logic wr, input logic [31:0] a);
    srad_pkg::rsp_t    res;
    srad_pkg::target_t tgt;
    logic [31:0]       loc;
    logic [31:0]       blk;
    logic              prot;
    tgt  = srad_pkg::TGT_NONE;
    loc  = '0;
    prot = 1'b0;
    if (a >= 32'hFFFE0000 && a <= 32'hFFFEFFFF) begin
      if (bios_reg[6]) begin
        tgt  = srad_pkg::TGT_ROM;
        loc  = a & srad_pkg::BIOS_MASK;
        prot = 1'b1;
      end
    end else if (a >= 32'hFFFF0000) begin
      if (bios_reg[5]) begin
        tgt  = srad_pkg::TGT_ROM;
        loc  = a & srad_pkg::BIOS_MASK;
        prot = 1'b1;
      end
    end else if (a >= 32'h000E0000 && a <= 32'h000EFFFF) begin
      // SMRAM at E0000 takes the whole segment and redirects it to A or B.
      if ((smram_reg & srad_pkg::SMRAM_E_MASK) == srad_pkg::SMRAM_E_MASK) begin
        tgt = srad_pkg::TGT_DRAM;
        loc = (smram_reg[3] ? 32'h000B0000 : 32'h000A0000) + (a - 32'h000E0000);
      end else begin
        bios_segment_lookup(a, bios_reg[6], 4, tgt, loc, prot);
      end
    end else if (a >= 32'h000F0000 && a <= 32'h000FFFFF) begin
      bios_segment_lookup(a, bios_reg[5], 6, tgt, loc, prot);
    end else if (a >= 32'h000C0000 && a <= 32'h000DFFFF) begin
      blk = (a - 32'h000C0000) >> 15;
      if (shadow_reg[blk[1:0]]) begin
        tgt = srad_pkg::TGT_DRAM;
        loc = a;
      end
    end else if (a <= 32'h0009FFFF) begin
      if (isa_reg[0]) begin
        tgt = srad_pkg::TGT_DRAM;
        loc = a;
      end
    end else if (a >= 32'h00100000 && a <= srad_pkg::RAM_LAST) begin
      tgt = srad_pkg::TGT_DRAM;
      loc = a;
    end
    res.target        = tgt;
    res.local_address = loc[srad_pkg::LOCAL_W-1:0];
    res.write_dropped = wr && prot && (tgt != srad_pkg::TGT_NONE);
    res.config_error  = (smram_reg & srad_pkg::SMRAM_ERR_MASK) == srad_pkg::SMRAM_ERR_VAL;
    return res;
  endfunction

  // Region boundaries that random accesses probe from both sides.
  function automatic logic [31:0] region_edge(input int k);
    case (k)
      0:       return 32'h00000000;
      1:       return 32'h000A0000;
      2:       return 32'h000C0000;
      3:       return 32'h000C8000;
      4:       return 32'h000D0000;
      5:       return 32'h000D8000;
      6:       return 32'h000E0000;
      7:       return 32'h000E8000;
      8:       return 32'h000F0000;
      9:       return 32'h000F8000;
      10:      return 32'h00100000;
      11:      return srad_pkg::RAM_BYTES;
      12:      return 32'hFFFE0000;
      default: return 32'hFFFF0000;
    endcase
  endfunction

  // Random address weighted toward the decoded regions.
  function automatic logic [31:0] random_address();
    case ($urandom_range(9))
      0:       return $urandom_range(32'h0009FFFF);
      1:       return 32'h000A0000 + $urandom_range(32'h1FFFF);
      2:       return 32'h000C0000 + $urandom_range(32'h1FFFF);
      3:       return 32'h000E0000 + $urandom_range(32'hFFFF);
      4:       return 32'h000F0000 + $urandom_range(32'hFFFF);
      5:       return 32'h00100000 + $urandom_range(srad_pkg::RAM_BYTES);
      6:       return 32'hFFFE0000 + $urandom_range(32'h1FFFF);
      7:       return region_edge($urandom_range(13)) + $urandom_range(2) - 32'd1;
      default: return $urandom();
    endcase
  endfunction

  // Offer one access, wait for it to be taken and record its expected decode.
  task automatic send_access(input logic wr, input logic [31:0] a);
    pending_decode_t entry;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid   <= 1'b1;
    req         <= '{req_type: wr, address: a};
    do @(posedge clk); while (req_stall !== 1'b0);
    entry.access = '{req_type: wr, address: a};
    entry.result = predict_decode(wr, a);
    pending_decodes.push_back(entry);
    @(negedge clk);
  endtask

  // Stop offering items and wait until every access has been decoded.
  task automatic drain_decoder();
    req_valid <= 1'b0;
    @(negedge clk);
    while (pending_decodes.size() != 0) @(negedge clk);
  endtask

  // Write one control register and keep the local copy in step.
  task automatic write_reg(input srad_pkg::reg_index_t idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      srad_pkg::REG_SHADOW: shadow_reg = value;
      srad_pkg::REG_SMRAM:  smram_reg  = value[7:0];
      srad_pkg::REG_BIOS:   bios_reg   = value[7:0];
      srad_pkg::REG_ISA:    isa_reg    = value[7:0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Every region under the register values left by reset.
  task automatic test_reset_map();
    send_access(1'b0, 32'h00000000);
    send_access(1'b1, 32'h0009FFFF);
    send_access(1'b0, 32'h000A0000);
    send_access(1'b1, 32'h000C0000);
    send_access(1'b1, 32'h000E0000);
    send_access(1'b0, 32'h000EFFFF);
    send_access(1'b1, 32'h000F8000);
    send_access(1'b0, 32'h00100000);
    send_access(1'b1, srad_pkg::RAM_LAST);
    send_access(1'b0, srad_pkg::RAM_BYTES);
    send_access(1'b0, 32'hFFFDFFFF);
    send_access(1'b1, 32'hFFFE0000);
    send_access(1'b0, 32'hFFFEFFFF);
    send_access(1'b1, 32'hFFFFFFFF);
    drain_decoder();
  endtask

  // SMRAM redirection, the unsupported SMRAM setting, half shadowed segments
  // with write protection, and disabled BIOS windows and base memory.
  task automatic test_special_cases();
    write_reg(srad_pkg::REG_SMRAM, 16'h0016);
    send_access(1'b1, 32'h000E0000);
    send_access(1'b0, 32'h000EFFFF);
    send_access(1'b1, 32'hFFFE0000);
    drain_decoder();
    write_reg(srad_pkg::REG_SMRAM, 16'h001E);
    send_access(1'b0, 32'h000E8000);
    drain_decoder();
    write_reg(srad_pkg::REG_SMRAM, 16'h0002);
    write_reg(srad_pkg::REG_SHADOW, 16'h0150);
    send_access(1'b1, 32'h000E0000);
    send_access(1'b0, 32'h000E8000);
    send_access(1'b1, 32'h000F0000);
    send_access(1'b0, 32'h000F8000);
    drain_decoder();
    write_reg(srad_pkg::REG_BIOS, 16'h0000);
    write_reg(srad_pkg::REG_ISA, 16'h0000);
    send_access(1'b0, 32'h000F0000);
    send_access(1'b0, 32'hFFFF0000);
    send_access(1'b1, 32'h00005000);
    send_access(1'b0, 32'h000C0000);
    drain_decoder();
  endtask

  // Random accesses across many register settings and idling patterns.
  task automatic test_random_traffic();
    logic [15:0] smram_value;
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 33;
          recv_idle_pct = 76;
        end
        1: begin
          send_idle_pct = 76;
          recv_idle_pct = 33;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int p = 0; p < 6; p++) begin
        // The first two settings of each pattern are the all-clear and all-set extremes.
        if (p == 0) begin
          write_reg(srad_pkg::REG_SHADOW, 16'h0000);
          write_reg(srad_pkg::REG_SMRAM, 16'h0000);
          write_reg(srad_pkg::REG_BIOS, 16'h0000);
          write_reg(srad_pkg::REG_ISA, 16'h0000);
        end else if (p == 1) begin
          write_reg(srad_pkg::REG_SHADOW, 16'hFFFF);
          write_reg(srad_pkg::REG_SMRAM, 16'hFFFF);
          write_reg(srad_pkg::REG_BIOS, 16'hFFFF);
          write_reg(srad_pkg::REG_ISA, 16'hFFFF);
        end else begin
          smram_value = 16'($urandom_range(16'hFFFF));
          case ($urandom_range(3))
            0:       smram_value = smram_value | 16'h0016;
            1:       smram_value = (smram_value & ~16'h0012) | 16'h0002;
            default: ;
          endcase
          write_reg(srad_pkg::REG_SHADOW, 16'($urandom_range(16'hFFFF)));
          write_reg(srad_pkg::REG_SMRAM, smram_value);
          write_reg(srad_pkg::REG_BIOS, 16'($urandom_range(16'hFFFF)));
          write_reg(srad_pkg::REG_ISA, 16'($urandom_range(16'hFFFF)));
        end
        settings_used++;
        for (int n = 0; n < 105; n++) begin
          send_access($urandom_range(1), random_address());
        end
        drain_decoder();
      end
    end
  endtask

  // The response side holds off for a long stretch while accesses keep coming.
  task automatic test_response_hold();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_go = 1'b1;
    @(negedge clk);
    for (int n = 0; n < 40; n++) begin
      send_access($urandom_range(1), random_address());
    end
    drain_decoder();
  endtask

  // Response stall: a single counted hold-off when requested, else random idling.
  always @(negedge clk) begin
    if (hold_go && !hold_begun) begin
      hold_begun <= 1'b1;
      hold_left  <= 299;
      rsp_stall  <= 1'b1;
    end else if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Compare each decoded access with the oldest expected decode.
  always @(posedge clk) begin : check_results
    pending_decode_t head;
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      results_seen++;
      if (pending_decodes.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("Unexpected decode result %h with no access outstanding", rsp);
        end
      end else begin
        head = pending_decodes.pop_front();
        if (rsp.target !== head.result.target ||
            rsp.local_address !== head.result.local_address ||
            rsp.write_dropped !== head.result.write_dropped ||
            rsp.config_error !== head.result.config_error) begin
          failures++;
          if (failures <= 10) begin
            $display("Mismatch for %s at %h: expected target %0d local %h dropped %b error %b,",
                     head.access.req_type ? "write" : "read", head.access.address,
                     head.result.target, head.result.local_address,
                     head.result.write_dropped, head.result.config_error);
            $display("  got target %0d local %h dropped %b error %b",
                     rsp.target, rsp.local_address, rsp.write_dropped, rsp.config_error);
          end
        end
        case (head.result.target)
          srad_pkg::TGT_DRAM: dram_hits++;
          srad_pkg::TGT_ROM:  rom_hits++;
          default:            unmapped_hits++;
        endcase
        if (head.result.write_dropped) dropped_writes++;
        if (head.result.config_error) error_flags++;
      end
    end
  end

  // Main sequence.
  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_reset_map();
    test_special_cases();
    test_random_traffic();
    test_response_hold();
    repeat (4) @(posedge clk);
    $display("Decoded %0d accesses: %0d to DRAM, %0d to BIOS ROM, %0d unmapped,",
             results_seen, dram_hits, rom_hits, unmapped_hits);
    $display("%0d dropped writes. Used %0d register settings, %0d accesses flagged SMRAM.",
             dropped_writes, settings_used, error_flags);
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #4_000_000;
    $display("Timeout with %0d accesses still outstanding", pending_decodes.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
